// ----- src/lng_pkg.sv -----
// Package for the lattice noise generator: item and config types, codes and
// default sizes. Used by lng_front, lng_back and the top level; depends on nothing.
`default_nettype none
package lng_pkg;
    localparam int TABLE_SIZE_DEF = 256;
    localparam int MAX_OCTAVES_DEF = 7;
    localparam int FRAC_BITS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CFG_IDX_MODE = 1'b0;
    localparam logic CFG_IDX_OCT = 1'b1;

    localparam logic [2:0] SEL_PERM_X = 3'd0;
    localparam logic [2:0] SEL_PERM_Y = 3'd1;
    localparam logic [2:0] SEL_PERM_Z = 3'd2;
    localparam logic [2:0] SEL_VALUE = 3'd3;
    localparam logic [2:0] SEL_GRAD = 3'd4;

    localparam logic [2:0] MODE_FLAT = 3'd0;
    localparam logic [2:0] MODE_LINEAR = 3'd1;
    localparam logic [2:0] MODE_SMOOTH = 3'd2;
    localparam logic [2:0] MODE_GRAD = 3'd3;
    localparam logic [2:0] MODE_TURB = 3'd4;

    localparam logic KIND_WRITE = 1'b0;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PX,
        OP_PY,
        OP_PZ,
        OP_VAL,
        OP_GRAD,
        OP_EVAL
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         index;
        logic [15:0]        value;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] octaves;
    } t_cfg;
endpackage
`default_nettype wire

// ----- src/lng_front.sv -----
// Front end: accepts input beats, classifies them into operations, queues
// them for the back end and holds the configuration registers. Uses lng_pkg.
`default_nettype none
module lng_front import lng_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_kind,
    input  wire logic [2:0]         i_table_select,
    input  wire logic [7:0]         i_table_index,
    input  wire logic [15:0]        i_entry_value,
    input  wire logic signed [15:0] i_entry_grad_x,
    input  wire logic signed [15:0] i_entry_grad_y,
    input  wire logic signed [15:0] i_entry_grad_z,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [2:0]         i_cfg_data,
    output t_cfg                    o_cfg,
    output logic                    o_q_valid,
    output t_item                   o_q_item,
    input  wire logic               i_q_pop
);
    t_item       r_q [QUEUE_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_cfg        r_cfg;
    t_item       n_item;
    logic        push;

    always_comb begin
        n_item.index = i_table_index;
        n_item.value = i_entry_value;
        n_item.gx = i_entry_grad_x;
        n_item.gy = i_entry_grad_y;
        n_item.gz = i_entry_grad_z;
        n_item.px = i_point_x;
        n_item.py = i_point_y;
        n_item.pz = i_point_z;
        if (i_kind == KIND_WRITE) begin
            case (i_table_select)
                SEL_PERM_X: n_item.op = OP_PX;
                SEL_PERM_Y: n_item.op = OP_PY;
                SEL_PERM_Z: n_item.op = OP_PZ;
                SEL_VALUE:  n_item.op = OP_VAL;
                SEL_GRAD:   n_item.op = OP_GRAD;
                default:    n_item.op = OP_NONE;
            endcase
        end else begin
            n_item.op = OP_EVAL;
        end
    end

    assign o_in_stall = (r_cnt == 2'(QUEUE_DEPTH));
    assign push = i_in_valid && !o_in_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_q[r_rp];
    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_cfg.mode <= MODE_GRAD;
            r_cfg.octaves <= 3'd7;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_MODE) begin
                    r_cfg.mode <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_OCT) begin
                    r_cfg.octaves <= i_cfg_data;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/lng_back.sv -----
// Back end: table memories, the corner sequencer with its shared datapath
// and the output register. Uses lng_pkg; fed by lng_front.
`default_nettype none
module lng_back import lng_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_q_valid,
    input  wire t_item              i_q_item,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [20:0]      o_noise_value
);
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int KW = $clog2(MAX_OCTAVES + 1);
    localparam int PW = 32 + MAX_OCTAVES;
    localparam logic [16:0] ONE = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE, S_SPLIT, S_FADE1, S_FADE2, S_PERM, S_LUT, S_W, S_ACC, S_OCT, S_FIN
    } t_state;

    logic [IW-1:0]      r_perm_x [TABLE_SIZE];
    logic [IW-1:0]      r_perm_y [TABLE_SIZE];
    logic [IW-1:0]      r_perm_z [TABLE_SIZE];
    logic [15:0]        r_value [TABLE_SIZE];
    logic [47:0]        r_grad [TABLE_SIZE];

    t_state             r_state;
    logic [2:0]         r_mode;
    logic [KW-1:0]      r_k, r_klast;
    logic [2:0]         r_j;
    logic signed [31:0] r_p [3];
    logic [IW-1:0]      r_cell [3];
    logic [15:0]        r_u [3];
    logic [31:0]        r_u2 [3];
    logic [16:0]        r_s [3];
    logic [IW-1:0]      r_px, r_py, r_pz;
    logic [15:0]        r_val;
    logic [47:0]        r_g;
    logic [16:0]        r_wxy, r_w;
    logic signed [35:0] r_dot;
    logic signed [56:0] r_acc;
    logic signed [31:0] r_turb;
    logic               r_ovalid;
    logic signed [20:0] r_out;

    logic [IW-1:0]      n_cell [3];
    logic signed [PW-1:0] q [3];
    logic [KW-1:0]      n_klast;
    logic [IW-1:0]      lut_addr;
    logic [16:0]        wx, wy, wz;
    logic signed [17:0] dx, dy, dz;
    logic signed [35:0] mul_b;
    logic signed [53:0] prod;
    logic signed [26:0] gres, gsh;
    logic signed [56:0] res;
    logic signed [20:0] sat;
    logic               smooth, out_free, idx_item;
    logic signed [33:0] c4 [3];

    assign smooth = (r_mode == MODE_SMOOTH) || (r_mode == MODE_GRAD) || (r_mode == MODE_TURB);
    assign out_free = !r_ovalid || !i_out_stall;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign idx_item = 1'b0;

    always_comb begin
        c4[0] = {r_p[0], 2'b00};
        c4[1] = {r_p[1], 2'b00};
        c4[2] = {r_p[2], 2'b00};
        for (int i = 0; i < 3; i++) begin
            q[i] = $signed({{MAX_OCTAVES{r_p[i][31]}}, r_p[i]}) <<< r_k;
            if (r_mode == MODE_FLAT) begin
                n_cell[i] = c4[i][FRAC_BITS+IW-1:FRAC_BITS]
                    + IW'(c4[i][33] && (c4[i][FRAC_BITS-1:0] != '0));
            end else begin
                n_cell[i] = q[i][FRAC_BITS+IW-1:FRAC_BITS];
            end
        end
        if (i_cfg.mode != MODE_TURB || i_cfg.octaves == 3'd0) begin
            n_klast = '0;
        end else if (int'(i_cfg.octaves) > MAX_OCTAVES) begin
            n_klast = KW'(MAX_OCTAVES - 1);
        end else begin
            n_klast = KW'(i_cfg.octaves - 3'd1);
        end
        lut_addr = r_px ^ r_py ^ r_pz;
        wx = r_j[2] ? r_s[0] : ONE - r_s[0];
        wy = r_j[1] ? r_s[1] : ONE - r_s[1];
        wz = r_j[0] ? r_s[2] : ONE - r_s[2];
        dx = $signed({2'b00, r_u[0]}) - $signed(r_j[2] ? 18'd65536 : 18'd0);
        dy = $signed({2'b00, r_u[1]}) - $signed(r_j[1] ? 18'd65536 : 18'd0);
        dz = $signed({2'b00, r_u[2]}) - $signed(r_j[0] ? 18'd65536 : 18'd0);
        mul_b = (r_mode == MODE_GRAD || r_mode == MODE_TURB) ? r_dot
                                                             : $signed({20'd0, r_val});
        prod = $signed({1'b0, r_w}) * mul_b;
        gres = r_acc[56:30];
        gsh = gres >>> r_k;
        case (r_mode)
            MODE_FLAT:   res = $signed({41'd0, r_val});
            MODE_LINEAR: res = r_acc >>> 16;
            MODE_SMOOTH: res = r_acc >>> 16;
            MODE_GRAD:   res = 57'(gres);
            MODE_TURB:   res = (r_turb < 0) ? -57'(r_turb) : 57'(r_turb);
            default:     res = '0;
        endcase
        if (res > 57'sd1048575) begin
            sat = 21'sd1048575;
        end else if (res < -57'sd1048576) begin
            sat = -21'sd1048576;
        end else begin
            sat = res[20:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            case (i_q_item.op)
                OP_PX:   r_perm_x[IW'(i_q_item.index)] <= IW'(i_q_item.value);
                OP_PY:   r_perm_y[IW'(i_q_item.index)] <= IW'(i_q_item.value);
                OP_PZ:   r_perm_z[IW'(i_q_item.index)] <= IW'(i_q_item.value);
                OP_VAL:  r_value[IW'(i_q_item.index)] <= i_q_item.value;
                OP_GRAD: r_grad[IW'(i_q_item.index)] <=
                             {i_q_item.gx, i_q_item.gy, i_q_item.gz};
                default: ;
            endcase
            r_p[0] <= i_q_item.px;
            r_p[1] <= i_q_item.py;
            r_p[2] <= i_q_item.pz;
            r_mode <= i_cfg.mode;
            r_klast <= n_klast;
        end
        case (r_state)
            S_SPLIT: begin
                for (int i = 0; i < 3; i++) begin
                    r_cell[i] <= n_cell[i];
                    r_u[i] <= q[i][FRAC_BITS-1:0];
                end
            end
            S_FADE1: begin
                for (int i = 0; i < 3; i++) begin
                    r_u2[i] <= r_u[i] * r_u[i];
                end
            end
            S_FADE2: begin
                for (int i = 0; i < 3; i++) begin
                    r_s[i] <= smooth
                        ? 17'((50'(r_u2[i]) * (18'd196608 - {1'b0, r_u[i], 1'b0})) >> 32)
                        : {1'b0, r_u[i]};
                end
            end
            S_PERM: begin
                r_px <= r_perm_x[r_cell[0] + IW'(r_j[2])];
                r_py <= r_perm_y[r_cell[1] + IW'(r_j[1])];
                r_pz <= r_perm_z[r_cell[2] + IW'(r_j[0])];
            end
            S_LUT: begin
                r_val <= r_value[lut_addr];
                r_g <= r_grad[lut_addr];
                r_wxy <= 17'((34'(wx) * 34'(wy)) >> 16);
            end
            S_W: begin
                r_w <= 17'((34'(r_wxy) * 34'(wz)) >> 16);
                r_dot <= 36'(dx * $signed(r_g[47:32])) + 36'(dy * $signed(r_g[31:16]))
                       + 36'(dz * $signed(r_g[15:0]));
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_k <= '0;
            r_j <= '0;
            r_acc <= '0;
            r_turb <= '0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_item.op == OP_EVAL) begin
                        r_k <= '0;
                        r_j <= '0;
                        r_acc <= '0;
                        r_turb <= '0;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: r_state <= (r_mode == MODE_FLAT) ? S_PERM : S_FADE1;
                S_FADE1: r_state <= S_FADE2;
                S_FADE2: r_state <= S_PERM;
                S_PERM:  r_state <= S_LUT;
                S_LUT:   r_state <= (r_mode == MODE_FLAT) ? S_FIN : S_W;
                S_W:     r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= r_acc + 57'(prod);
                    r_j <= r_j + 3'd1;
                    r_state <= (r_j == 3'd7) ? S_OCT : S_PERM;
                end
                S_OCT: begin
                    r_turb <= r_turb + 32'(gsh);
                    if (r_k != r_klast) begin
                        r_k <= r_k + KW'(1);
                        r_acc <= '0;
                        r_state <= S_SPLIT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out <= sat;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid || idx_item;
    assign o_noise_value = r_out;
endmodule
`default_nettype wire

// ----- src/lattice_noise_generator.sv -----
// Top level of the 3-D lattice noise generator: front end with item queue,
// back end with tables and datapath. Uses lng_pkg, lng_front and lng_back.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | kind, table fields, point
//   out     | output    | o_out_valid / i_out_stall | noise_value
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A table write is done in the back end as it leaves the queue. Mode 0 runs the
// split, permutation, lookup and finish steps; modes 1 to 3 add the fade steps and
// take the eight corners one at a time through the shared multiply and accumulate
// path; turbulence repeats the octave part once per octave. Reset clears the queue,
// sequencer and output valid; tables hold nothing defined until written. A stalled
// output holds the back end, and a full two-entry queue then stalls the input.
`default_nettype none
module lattice_noise_generator import lng_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_kind,
    input  wire logic [2:0]         i_table_select,
    input  wire logic [7:0]         i_table_index,
    input  wire logic [15:0]        i_entry_value,
    input  wire logic signed [15:0] i_entry_grad_x,
    input  wire logic signed [15:0] i_entry_grad_y,
    input  wire logic signed [15:0] i_entry_grad_z,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [20:0]      o_noise_value,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [2:0]         i_cfg_data
);
    t_cfg  cfg;
    logic  q_valid, q_pop;
    t_item q_item;

    lng_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_kind, .i_table_select,
        .i_table_index, .i_entry_value, .i_entry_grad_x, .i_entry_grad_y,
        .i_entry_grad_z, .i_point_x, .i_point_y, .i_point_z,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_cfg(cfg), .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    lng_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_OCTAVES(MAX_OCTAVES)) u_back (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_q_valid(q_valid), .i_q_item(q_item),
        .o_q_pop(q_pop), .o_out_valid, .i_out_stall, .o_noise_value
    );
endmodule
`default_nettype wire

// ----- src/lng_checker.sv -----
// Port-level checks for the lattice noise generator and the bind that
// attaches them to the top level. Depends on lattice_noise_generator.
`default_nettype none
module lng_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic signed [20:0] o_noise_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_noise_value))
        else $error("stalled output beat changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left a beat pending");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall rose without an accepted beat");
endmodule

bind lattice_noise_generator lng_checker u_lng_checker (.*);
`default_nettype wire

// ----- tb/sv/lattice_noise_generator_checker.sv -----
// Checker for the lattice noise generator: watches the input, output and config
// channels, predicts every noise result and compares it. Depends on lng_pkg.
module lattice_noise_generator_checker import lng_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_kind,
    input  logic [2:0]         i_table_select,
    input  logic [7:0]         i_table_index,
    input  logic [15:0]        i_entry_value,
    input  logic signed [15:0] i_entry_grad_x,
    input  logic signed [15:0] i_entry_grad_y,
    input  logic signed [15:0] i_entry_grad_z,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [20:0] i_noise_value,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [2:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]         perm_x [256];
    logic [7:0]         perm_y [256];
    logic [7:0]         perm_z [256];
    logic [15:0]        lattice_vals [256];
    logic signed [15:0] grad_x [256];
    logic signed [15:0] grad_y [256];
    logic signed [15:0] grad_z [256];
    logic [2:0]         noise_mode;
    logic [2:0]         octave_count;
    logic signed [20:0] noise_expected [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic longint fade_q16(longint u);
        return ((u * u) * (3 * 65536 - 2 * u)) >>> 32;
    endfunction

    function automatic logic [7:0] corner_index(longint cx, longint cy, longint cz);
        return perm_x[cx[7:0]] ^ perm_y[cy[7:0]] ^ perm_z[cz[7:0]];
    endfunction

    function automatic longint corner_weight(longint wx, longint wy, longint wz);
        return (((wx * wy) >>> 16) * wz) >>> 16;
    endfunction

    function automatic longint value_noise_q16(longint px, longint py, longint pz, bit smooth);
        longint c [3];
        longint u [3];
        longint p [3];
        longint sum;
        longint w;
        logic [7:0] idx;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = p[i] >>> 16;
            u[i] = p[i] & 64'hffff;
            if (smooth) u[i] = fade_q16(u[i]);
        end
        for (int l = 0; l < 2; l++)
            for (int m = 0; m < 2; m++)
                for (int n = 0; n < 2; n++) begin
                    w = corner_weight(l ? u[0] : 65536 - u[0], m ? u[1] : 65536 - u[1],
                                      n ? u[2] : 65536 - u[2]);
                    idx = corner_index(c[0] + l, c[1] + m, c[2] + n);
                    sum += w * longint'(lattice_vals[idx]);
                end
        return sum >>> 16;
    endfunction

    function automatic longint gradient_noise_q16(longint px, longint py, longint pz);
        longint c [3];
        longint u [3];
        longint s [3];
        longint p [3];
        longint sum;
        longint w;
        longint dot;
        logic [7:0] idx;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = p[i] >>> 16;
            u[i] = p[i] & 64'hffff;
            s[i] = fade_q16(u[i]);
        end
        for (int l = 0; l < 2; l++)
            for (int m = 0; m < 2; m++)
                for (int n = 0; n < 2; n++) begin
                    w = corner_weight(l ? s[0] : 65536 - s[0], m ? s[1] : 65536 - s[1],
                                      n ? s[2] : 65536 - s[2]);
                    idx = corner_index(c[0] + l, c[1] + m, c[2] + n);
                    dot = (u[0] - (l ? 65536 : 0)) * longint'(grad_x[idx])
                        + (u[1] - (m ? 65536 : 0)) * longint'(grad_y[idx])
                        + (u[2] - (n ? 65536 : 0)) * longint'(grad_z[idx]);
                    sum += w * dot;
                end
        return sum >>> 30;
    endfunction

    function automatic logic signed [20:0] predict_noise(longint px, longint py, longint pz);
        longint r;
        int octaves;
        r = 0;
        case (noise_mode)
            MODE_FLAT: r = lattice_vals[corner_index((px * 4) / 65536, (py * 4) / 65536,
                                                     (pz * 4) / 65536)];
            MODE_LINEAR: r = value_noise_q16(px, py, pz, 1'b0);
            MODE_SMOOTH: r = value_noise_q16(px, py, pz, 1'b1);
            MODE_GRAD: r = gradient_noise_q16(px, py, pz);
            MODE_TURB: begin
                octaves = (octave_count == 0) ? 1 : octave_count;
                for (int k = 0; k < octaves; k++)
                    r += gradient_noise_q16(px <<< k, py <<< k, pz <<< k) >>> k;
                if (r < 0) r = -r;
            end
            default: r = 0;
        endcase
        if (r > 1048575) r = 1048575;
        if (r < -1048576) r = -1048576;
        return r[20:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic signed [20:0] want;
        if (!i_rst_n) begin
            noise_mode = MODE_GRAD;
            octave_count = 3'd7;
            noise_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_MODE) noise_mode = i_cfg_data;
                else octave_count = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_WRITE) begin
                    case (i_table_select)
                        SEL_PERM_X: perm_x[i_table_index] = i_entry_value[7:0];
                        SEL_PERM_Y: perm_y[i_table_index] = i_entry_value[7:0];
                        SEL_PERM_Z: perm_z[i_table_index] = i_entry_value[7:0];
                        SEL_VALUE: lattice_vals[i_table_index] = i_entry_value;
                        SEL_GRAD: begin
                            grad_x[i_table_index] = i_entry_grad_x;
                            grad_y[i_table_index] = i_entry_grad_y;
                            grad_z[i_table_index] = i_entry_grad_z;
                        end
                        default: ;
                    endcase
                end else begin
                    noise_expected.push_back(predict_noise(longint'(i_point_x),
                        longint'(i_point_y), longint'(i_point_z)));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (noise_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected noise beat %0d", i_noise_value));
                end else begin
                    want = noise_expected.pop_front();
                    if (i_noise_value !== want)
                        report_mismatch($sformatf("noise_value got %0d expected %0d",
                                                  i_noise_value, want));
                end
            end
        end
        o_pending = noise_expected.size();
    end
endmodule

// ----- tb/sv/lattice_noise_generator_tb.sv -----
// Testbench top for the lattice noise generator: clock, reset, table loading,
// config phases and random stimulus. Depends on lng_pkg, the block and its checker.
module lattice_noise_generator_tb import lng_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [2:0]         i_table_select;
    logic [7:0]         i_table_index;
    logic [15:0]        i_entry_value;
    logic signed [15:0] i_entry_grad_x;
    logic signed [15:0] i_entry_grad_y;
    logic signed [15:0] i_entry_grad_z;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [20:0] o_noise_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [2:0]         i_cfg_data;
    int                 fail_count;
    int                 noise_pending;
    int                 burst_left;
    int                 idle_cycles;
    int                 stall_cycle;
    int                 stall_style;

    lattice_noise_generator DUT (.*);

    lattice_noise_generator_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_kind, .i_table_select,
        .i_table_index, .i_entry_value, .i_entry_grad_x, .i_entry_grad_y, .i_entry_grad_z,
        .i_point_x, .i_point_y, .i_point_z, .i_out_valid(o_out_valid), .i_out_stall,
        .i_noise_value(o_noise_value), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(noise_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cycle <= 0;
            stall_style <= 0;
        end else begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 150 == 0) stall_style <= $urandom_range(0, 2);
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                default: i_out_stall <= (stall_cycle % 16 < 10);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == 5000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_beat(logic kind, logic [2:0] sel, logic [7:0] idx,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_table_select <= sel;
        i_table_index <= idx;
        i_entry_value <= 16'($urandom());
        i_entry_grad_x <= 16'($urandom());
        i_entry_grad_y <= 16'($urandom());
        i_entry_grad_z <= 16'($urandom());
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (noise_pending != 0);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_config(logic idx, logic [2:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(logic [2:0] mode, logic [2:0] octaves);
        wait_drained();
        write_config(CFG_IDX_MODE, mode);
        write_config(CFG_IDX_OCT, octaves);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
            2: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            default: return {16'(int'($urandom_range(0, 7)) - 4), 16'($urandom())};
        endcase
    endfunction

    logic [31:0] extreme_pts [6] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff, 32'h1, 32'h0000_ffff};
    logic [2:0]  phase_mode [12] = '{MODE_FLAT, MODE_LINEAR, MODE_SMOOTH, MODE_GRAD,
                                     MODE_TURB, MODE_TURB, MODE_TURB, 3'd5, 3'd7,
                                     MODE_GRAD, MODE_SMOOTH, MODE_TURB};
    logic [2:0]  phase_oct [12] = '{3'd1, 3'd7, 3'd3, 3'd0, 3'd7, 3'd1, 3'd0, 3'd2,
                                    3'd5, 3'd4, 3'd6, 3'd3};

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = 1'b0;
        i_table_select = '0;
        i_table_index = '0;
        i_entry_value = '0;
        i_entry_grad_x = '0;
        i_entry_grad_y = '0;
        i_entry_grad_z = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry of every table is written before the first evaluation.
        for (int sel = 0; sel < 5; sel++)
            for (int idx = 0; idx < 256; idx++)
                send_beat(KIND_WRITE, 3'(sel), 8'(idx), $urandom(), $urandom(), $urandom());

        for (int mode = 0; mode < 5; mode++) begin
            set_phase(3'(mode), 3'd7);
            for (int i = 0; i < 5; i++)
                send_beat(~KIND_WRITE, 3'($urandom()), 8'($urandom()), extreme_pts[i],
                          extreme_pts[(i + 1) % 6], extreme_pts[(i + 2) % 6]);
        end

        for (int ph = 0; ph < 12; ph++) begin
            set_phase(phase_mode[ph], phase_oct[ph]);
            for (int i = 0; i < 32; i++) begin
                if ($urandom_range(0, 99) < 15)
                    send_beat(KIND_WRITE, 3'($urandom_range(0, 7)), 8'($urandom()),
                              $urandom(), $urandom(), $urandom());
                else
                    send_beat(~KIND_WRITE, 3'($urandom()), 8'($urandom()), pick_coord(),
                              pick_coord(), pick_coord());
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
src/lng_pkg.sv
src/lng_front.sv
src/lng_back.sv
src/lattice_noise_generator.sv
src/lng_checker.sv
tb/sv/lattice_noise_generator_checker.sv
tb/sv/lattice_noise_generator_tb.sv
